// ----- design/nsr_pkg.sv -----
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared constants, the x width function and the seed function of the Newton square root core.
// ----------------------------------------------------------------------------
package nsr_pkg;

    localparam int unsigned RADICAND_BITS_DEF = 31;
    localparam int unsigned NEWTON_STEPS_DEF  = 2;
    localparam int unsigned FRACTION_BITS_DEF = 16;

    localparam int unsigned INT_BITS  = 34;
    localparam int unsigned ROOT_BITS = 16;

    // Fixed-point width of x: integer plus fraction bits, capped at 63.
    function automatic int unsigned x_width(input int unsigned frac);
        x_width = (INT_BITS + frac >= 63) ? 63 : INT_BITS + frac;
    endfunction

    // Seed 2^(floor(p/2) + frac), p the leading one of n, clamped to the format.
    function automatic logic [63:0] seed_x(input logic [63:0] n,
                                           input int unsigned frac,
                                           input int unsigned xw);
        int unsigned p;
        int unsigned sh;
        logic [63:0] lim;
        logic [63:0] s;
        p = 0;
        for (int unsigned k = 0; k < 64; k++) begin
            if (n[k]) p = k;
        end
        sh  = p / 2 + frac;
        lim = (64'd1 << xw) - 64'd1;
        s   = (sh >= 63) ? lim : (64'd1 << sh);
        if (s > lim) s = lim;
        seed_x = s;
    endfunction

endpackage

// ----- design/nsr_div_cell.sv -----
// ----------------------------------------------------------------------------
// nsr_div_cell
// One restoring division cell: develops one quotient bit per cycle while i_en is high.
// ----------------------------------------------------------------------------
module nsr_div_cell #(
    parameter int unsigned R_BITS = nsr_pkg::RADICAND_BITS_DEF,
    parameter int unsigned X_BITS = 50,
    parameter int unsigned D_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [R_BITS-1:0] i_n,
    input  logic [X_BITS-1:0] i_x,
    input  logic [X_BITS:0]   i_rem,
    input  logic [D_BITS-1:0] i_num,
    input  logic [D_BITS-1:0] i_quo,
    output logic              o_valid,
    output logic [R_BITS-1:0] o_n,
    output logic [X_BITS-1:0] o_x,
    output logic [X_BITS:0]   o_rem,
    output logic [D_BITS-1:0] o_num,
    output logic [D_BITS-1:0] o_quo
);

    logic              r_valid;
    logic [R_BITS-1:0] r_n;
    logic [X_BITS-1:0] r_x;
    logic [X_BITS:0]   r_rem;
    logic [D_BITS-1:0] r_num;
    logic [D_BITS-1:0] r_quo;

    logic [X_BITS+1:0] w_trial;
    logic [X_BITS+1:0] w_div;
    logic              w_bit;
    logic [X_BITS:0]   n_rem;

    always_comb begin
        w_trial = {i_rem, i_num[D_BITS-1]};
        w_div   = {1'b0, i_x, 1'b0};
        w_bit   = (w_trial >= w_div);
        n_rem   = w_bit ? (X_BITS+1)'(w_trial - w_div) : w_trial[X_BITS:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= i_n;
            r_x   <= i_x;
            r_rem <= n_rem;
            r_num <= {i_num[D_BITS-2:0], 1'b0};
            r_quo <= {i_quo[D_BITS-2:0], w_bit};
        end
    end

    assign o_valid = r_valid;
    assign o_n     = r_n;
    assign o_x     = r_x;
    assign o_rem   = r_rem;
    assign o_num   = r_num;
    assign o_quo   = r_quo;

endmodule

// ----- design/nsr_step.sv -----
// ----------------------------------------------------------------------------
// nsr_step
// One Newton step x' = floor((x*x + n*2^2F) / 2x) as a row of division cells.
// ----------------------------------------------------------------------------
module nsr_step #(
    parameter int unsigned R_BITS    = nsr_pkg::RADICAND_BITS_DEF,
    parameter int unsigned FRAC_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [R_BITS-1:0] i_n,
    input  logic [nsr_pkg::x_width(FRAC_BITS)-1:0] i_x,
    output logic              o_valid,
    output logic [R_BITS-1:0] o_n,
    output logic [nsr_pkg::x_width(FRAC_BITS)-1:0] o_x
);

    localparam int unsigned W  = nsr_pkg::x_width(FRAC_BITS);
    localparam int unsigned NW = R_BITS + 2 * FRAC_BITS;
    localparam int unsigned DW = ((NW > W) ? NW : W) + 1;
    localparam logic [W-1:0] LIM = '1;

    // Numerator is n*2^2F plus x when x is odd; (x >> 1) is added back after.
    logic              r_valid;
    logic [R_BITS-1:0] r_n;
    logic [W-1:0]      r_x;
    logic [DW-1:0]     r_num;
    logic [DW-1:0]     n_num;

    always_comb begin
        n_num = (DW'(i_n) << (2 * FRAC_BITS)) + DW'(i_x & {W{i_x[0]}});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n   <= i_n;
            r_x   <= i_x;
            r_num <= n_num;
        end
    end

    logic              c_valid [0:DW];
    logic [R_BITS-1:0] c_n     [0:DW];
    logic [W-1:0]      c_x     [0:DW];
    logic [W:0]        c_rem   [0:DW];
    logic [DW-1:0]     c_num   [0:DW];
    logic [DW-1:0]     c_quo   [0:DW];

    assign c_valid[0] = r_valid;
    assign c_n[0]     = r_n;
    assign c_x[0]     = r_x;
    assign c_rem[0]   = '0;
    assign c_num[0]   = r_num;
    assign c_quo[0]   = '0;

    for (genvar g = 0; g < DW; g++) begin : g_cell
        nsr_div_cell #(
            .R_BITS (R_BITS),
            .X_BITS (W),
            .D_BITS (DW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (c_valid[g]),
            .i_n     (c_n[g]),
            .i_x     (c_x[g]),
            .i_rem   (c_rem[g]),
            .i_num   (c_num[g]),
            .i_quo   (c_quo[g]),
            .o_valid (c_valid[g+1]),
            .o_n     (c_n[g+1]),
            .o_x     (c_x[g+1]),
            .o_rem   (c_rem[g+1]),
            .o_num   (c_num[g+1]),
            .o_quo   (c_quo[g+1])
        );
    end

    logic              r_out_valid;
    logic [R_BITS-1:0] r_out_n;
    logic [W-1:0]      r_out_x;
    logic [DW:0]       w_sum;
    logic [W-1:0]      n_out_x;

    // Saturate to the format; a zero x stays zero.
    always_comb begin
        w_sum = (DW+1)'(c_x[DW] >> 1) + (DW+1)'(c_quo[DW]);
        if (c_x[DW] == '0) begin
            n_out_x = '0;
        end else if (w_sum > (DW+1)'(LIM)) begin
            n_out_x = LIM;
        end else begin
            n_out_x = w_sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= c_valid[DW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_n <= c_n[DW];
            r_out_x <= n_out_x;
        end
    end

    assign o_valid = r_out_valid;
    assign o_n     = r_out_n;
    assign o_x     = r_out_x;

endmodule

// ----- design/newton_square_root_core.sv -----
// ----------------------------------------------------------------------------
// newton_square_root_core
// Pipelined integer square root: power-of-two seed and Newton steps.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one radicand per transaction in tdata
//   (bits RADICAND_BITS-1:0, upper pad bits ignored). Master stream m_axis
//   returns one root per transaction in tdata[15:0], in input order.
//   Each Newton step is a row of DW division cells, one quotient bit each,
//   between an input and an output register; DW = max(RADICAND_BITS +
//   2*FRACTION_BITS, XW) + 1, XW = min(34 + FRACTION_BITS, 63). A seed
//   register leads and an output register ends the pipeline. Unless the
//   receiver stalls, the rate is one new radicand per cycle.
//   All stages advance together while the output register is empty or
//   being taken; when the receiver stalls with a result held, the whole
//   row holds and s_axis tready drops.
//   Reset empties every stage; nothing is emitted until new input arrives.
// ----------------------------------------------------------------------------
module newton_square_root_core #(
    parameter int unsigned RADICAND_BITS = nsr_pkg::RADICAND_BITS_DEF,
    parameter int unsigned NEWTON_STEPS  = nsr_pkg::NEWTON_STEPS_DEF,
    parameter int unsigned FRACTION_BITS = nsr_pkg::FRACTION_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // radicand [RADICAND_BITS-1:0], zero pad above
    input  logic [((RADICAND_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // root [15:0]
    output logic [nsr_pkg::ROOT_BITS-1:0] o_m_axis_tdata
);

    localparam int unsigned W = nsr_pkg::x_width(FRACTION_BITS);
    localparam int unsigned IW = W - FRACTION_BITS;
    localparam int unsigned RB = nsr_pkg::ROOT_BITS;

    logic w_en;
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    logic                     r_seed_valid;
    logic [RADICAND_BITS-1:0] r_seed_n;
    logic [W-1:0]             r_seed_x;
    logic [RADICAND_BITS-1:0] w_in_n;
    logic [W-1:0]             n_seed_x;

    always_comb begin
        w_in_n   = i_s_axis_tdata[RADICAND_BITS-1:0];
        n_seed_x = W'(nsr_pkg::seed_x(64'(w_in_n), FRACTION_BITS, W));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_valid <= 1'b0;
        end else if (w_en) begin
            r_seed_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_seed_n <= w_in_n;
            r_seed_x <= n_seed_x;
        end
    end

    logic                     s_valid [0:NEWTON_STEPS];
    logic [RADICAND_BITS-1:0] s_n     [0:NEWTON_STEPS];
    logic [W-1:0]             s_x     [0:NEWTON_STEPS];

    assign s_valid[0] = r_seed_valid;
    assign s_n[0]     = r_seed_n;
    assign s_x[0]     = r_seed_x;

    for (genvar g = 0; g < NEWTON_STEPS; g++) begin : g_step
        nsr_step #(
            .R_BITS    (RADICAND_BITS),
            .FRAC_BITS (FRACTION_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (s_valid[g]),
            .i_n     (s_n[g]),
            .i_x     (s_x[g]),
            .o_valid (s_valid[g+1]),
            .o_n     (s_n[g+1]),
            .o_x     (s_x[g+1])
        );
    end

    logic          r_out_valid;
    logic [RB-1:0] r_root;
    logic [IW-1:0] w_int;
    logic [RB-1:0] n_root;

    // Drop the fraction; clamp roots that need more than 16 bits.
    always_comb begin
        w_int  = s_x[NEWTON_STEPS][W-1:FRACTION_BITS];
        n_root = (|w_int[IW-1:RB]) ? '1 : w_int[RB-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= s_valid[NEWTON_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_root <= n_root;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_root;

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_seed_pow2 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seed_valid |-> $onehot(r_seed_x))
        else $error("seed is not a power of two");

    a_x_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_valid[NEWTON_STEPS] |-> (s_x[NEWTON_STEPS] != '0))
        else $error("Newton estimate collapsed to zero");

endmodule

// ----- tb/newton_square_root_core_test.sv -----
// ----------------------------------------------------------------------------
// newton_square_root_core_test
// Streams radicands through the square root core under phases of input idling
// and receiver stalls, and checks every root against a fixed-point Newton predictor.
// ----------------------------------------------------------------------------
class root_scoreboard;
    logic [15:0] roots_due[$];
    int          n_errors;

    function new();
        n_errors = 0;
    endfunction

    // Newton step: floor((X*X + n*2^32) / (2X)), saturated to the 50-bit format.
    static function logic [63:0] newton_iter(logic [63:0] x, logic [63:0] n);
        logic [127:0] num;
        logic [127:0] q;
        logic [63:0]  lim;
        lim = (64'd1 << (nsr_pkg::INT_BITS + 16)) - 64'd1;
        if (x == 64'd0) return 64'd0;
        num = 128'(x) * 128'(x) + (128'(n) << 32);
        q   = num / (128'(x) << 1);
        return (q > 128'(lim)) ? lim : q[63:0];
    endfunction

    static function logic [15:0] predict_root(logic [30:0] rad);
        logic [63:0] x;
        int          lead;
        lead = 0;
        for (int k = 0; k < 31; k++) if (rad[k]) lead = k;
        x = 64'd1 << (lead / 2 + 16);
        for (int i = 0; i < 2; i++) x = newton_iter(x, 64'(rad));
        x = x >> 16;
        return (x > 64'd65535) ? 16'hFFFF : x[15:0];
    endfunction

    function void note_radicand(logic [30:0] rad);
        roots_due.push_back(predict_root(rad));
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH %s", msg);
        n_errors++;
    endtask

    task check_root(logic [15:0] got);
        logic [15:0] want;
        if (roots_due.size() == 0) begin
            report_mismatch($sformatf("unexpected root %0d", got));
            return;
        end
        want = roots_due.pop_front();
        if (got !== want) report_mismatch($sformatf("root %0d, want %0d", got, want));
    endtask
endclass

module newton_square_root_core_test;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // radicand [30:0], zero pad [31]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;   // root [15:0]

    root_scoreboard sb;
    int  idle_pct;
    int  stall_pct;
    longint cycles;

    newton_square_root_core DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: stall at random, check each transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) sb.check_root(o_m_axis_tdata);
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task send_radicand(logic [30:0] rad);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, rad};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_radicand(rad);
    endtask

    function logic [30:0] random_radicand();
        int w;
        w = $urandom_range(31, 1);
        return 31'($urandom) & ((31'h7FFFFFFF) >> (31 - w));
    endfunction

    initial begin
        logic [30:0] directed[$];
        sb = new();
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd15, 31'd16, 31'd17,
                     31'd255, 31'd256, 31'd65535, 31'd65536, 31'h55555555,
                     31'h2AAAAAAA, 31'h40000000, 31'h3FFFFFFF, 31'h7FFFFFFF,
                     31'd1000000, 31'd99999999};
        foreach (directed[i]) send_radicand(directed[i]);
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 34 : 0;
            stall_pct = (ph == 2) ? 59 : (ph == 3) ? 34 : 0;
            for (int i = 0; i < 185; i++) send_radicand(random_radicand());
            if (ph == 1) begin
                // hold off until the pipeline has drained
                i_s_axis_tvalid <= 1'b0;
                while (sb.roots_due.size() != 0) @(posedge i_clk);
            end
        end
        i_s_axis_tvalid <= 1'b0;
        while (sb.roots_due.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
